// File: hdl/rvid_pkg.sv
// Shared opcodes, mnemonic codes and decoded-record type for the RV32I decoder.
`timescale 1ns / 1ps
`default_nettype none
package rvid_pkg;

    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_IMM    = 7'b0010011;
    localparam logic [6:0] OPC_REG    = 7'b0110011;
    localparam logic [6:0] OPC_FENCE  = 7'b0001111;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    localparam logic [11:0] F12_ECALL  = 12'd0;
    localparam logic [11:0] F12_EBREAK = 12'd1;

    localparam int MnemonicWidth = 6;
    localparam int ImmWidth      = 21;

    localparam logic [5:0] MN_UNKNOWN = 6'd0;
    localparam logic [5:0] MN_LUI     = 6'd1;
    localparam logic [5:0] MN_AUIPC   = 6'd2;
    localparam logic [5:0] MN_JAL     = 6'd3;
    localparam logic [5:0] MN_JALR    = 6'd4;
    localparam logic [5:0] MN_BEQ     = 6'd5;
    localparam logic [5:0] MN_BNE     = 6'd6;
    localparam logic [5:0] MN_BLT     = 6'd7;
    localparam logic [5:0] MN_BGE     = 6'd8;
    localparam logic [5:0] MN_BLTU    = 6'd9;
    localparam logic [5:0] MN_BGEU    = 6'd10;
    localparam logic [5:0] MN_LB      = 6'd11;
    localparam logic [5:0] MN_LH      = 6'd12;
    localparam logic [5:0] MN_LW      = 6'd13;
    localparam logic [5:0] MN_LBU     = 6'd14;
    localparam logic [5:0] MN_LHU     = 6'd15;
    localparam logic [5:0] MN_SB      = 6'd16;
    localparam logic [5:0] MN_SH      = 6'd17;
    localparam logic [5:0] MN_SW      = 6'd18;
    localparam logic [5:0] MN_ADDI    = 6'd19;
    localparam logic [5:0] MN_SLTI    = 6'd20;
    localparam logic [5:0] MN_SLTIU   = 6'd21;
    localparam logic [5:0] MN_XORI    = 6'd22;
    localparam logic [5:0] MN_ORI     = 6'd23;
    localparam logic [5:0] MN_ANDI    = 6'd24;
    localparam logic [5:0] MN_SLLI    = 6'd25;
    localparam logic [5:0] MN_SRLI    = 6'd26;
    localparam logic [5:0] MN_SRAI    = 6'd27;
    localparam logic [5:0] MN_ADD     = 6'd28;
    localparam logic [5:0] MN_SUB     = 6'd29;
    localparam logic [5:0] MN_SLL     = 6'd30;
    localparam logic [5:0] MN_SLT     = 6'd31;
    localparam logic [5:0] MN_SLTU    = 6'd32;
    localparam logic [5:0] MN_XOR     = 6'd33;
    localparam logic [5:0] MN_SRL     = 6'd34;
    localparam logic [5:0] MN_SRA     = 6'd35;
    localparam logic [5:0] MN_OR      = 6'd36;
    localparam logic [5:0] MN_AND     = 6'd37;
    localparam logic [5:0] MN_FENCE   = 6'd38;
    localparam logic [5:0] MN_FENCE_I = 6'd39;
    localparam logic [5:0] MN_ECALL   = 6'd40;
    localparam logic [5:0] MN_EBREAK  = 6'd41;
    localparam logic [5:0] MN_CSRRW   = 6'd42;
    localparam logic [5:0] MN_CSRRS   = 6'd43;
    localparam logic [5:0] MN_CSRRC   = 6'd44;
    localparam logic [5:0] MN_CSRRWI  = 6'd45;
    localparam logic [5:0] MN_CSRRSI  = 6'd46;
    localparam logic [5:0] MN_CSRRCI  = 6'd47;

    typedef struct packed {
        logic [31:0]                target_address;
        logic [3:0]                 fence_succ;
        logic [3:0]                 fence_pred;
        logic [11:0]                csr_number;
        logic signed [ImmWidth-1:0] immediate;
        logic [4:0]                 src2_reg;
        logic [4:0]                 src1_reg;
        logic [4:0]                 dest_reg;
        logic [MnemonicWidth-1:0]   mnemonic;
    } dec_t;

endpackage
`default_nettype wire

// File: hdl/rvid_decode.sv
// Combinational RV32I decode of one instruction word and its address.
`timescale 1ns / 1ps
`default_nettype none
module rvid_decode (
    input  wire logic [31:0] instr_word,
    input  wire logic [31:0] instr_address,
    output rvid_pkg::dec_t   dec
);

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [11:0] f12;
    logic [20:0] imm_u;
    logic [20:0] imm_i;
    logic [20:0] imm_s;
    logic [20:0] imm_b;
    logic [20:0] imm_j;
    logic [20:0] shamt;
    logic [31:0] tgt_b;
    logic [31:0] tgt_j;
    logic [5:0]  mn;
    logic [20:0] imm;
    logic [11:0] csr;
    logic [3:0]  pred;
    logic [3:0]  succ;
    logic [31:0] tgt;

    assign opc = instr_word[6:0];
    assign f3  = instr_word[14:12];
    assign f7  = instr_word[31:25];
    assign f12 = instr_word[31:20];

    assign imm_u = {instr_word[31], instr_word[31:12]};
    assign imm_i = {{9{instr_word[31]}}, instr_word[31:20]};
    assign imm_s = {{9{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
    assign imm_b = {{8{instr_word[31]}}, instr_word[31], instr_word[7],
                    instr_word[30:25], instr_word[11:8], 1'b0};
    assign imm_j = {instr_word[31], instr_word[19:12], instr_word[20],
                    instr_word[30:21], 1'b0};
    assign shamt = {16'd0, instr_word[24:20]};

    assign tgt_b = instr_address + {{11{imm_b[20]}}, imm_b};
    assign tgt_j = instr_address + {{11{imm_j[20]}}, imm_j};

    always_comb begin
        mn   = rvid_pkg::MN_UNKNOWN;
        imm  = '0;
        csr  = '0;
        pred = '0;
        succ = '0;
        tgt  = '0;
        unique case (opc)
            rvid_pkg::OPC_LUI: begin
                mn  = rvid_pkg::MN_LUI;
                imm = imm_u;
            end
            rvid_pkg::OPC_AUIPC: begin
                mn  = rvid_pkg::MN_AUIPC;
                imm = imm_u;
            end
            rvid_pkg::OPC_JAL: begin
                mn  = rvid_pkg::MN_JAL;
                imm = imm_j;
                tgt = tgt_j;
            end
            rvid_pkg::OPC_JALR: begin
                mn  = rvid_pkg::MN_JALR;
                imm = imm_i;
            end
            rvid_pkg::OPC_BRANCH: begin
                unique case (f3)
                    3'd0:    mn = rvid_pkg::MN_BEQ;
                    3'd1:    mn = rvid_pkg::MN_BNE;
                    3'd4:    mn = rvid_pkg::MN_BLT;
                    3'd5:    mn = rvid_pkg::MN_BGE;
                    3'd6:    mn = rvid_pkg::MN_BLTU;
                    3'd7:    mn = rvid_pkg::MN_BGEU;
                    default: mn = rvid_pkg::MN_UNKNOWN;
                endcase
                if (mn != rvid_pkg::MN_UNKNOWN) begin
                    imm = imm_b;
                    tgt = tgt_b;
                end
            end
            rvid_pkg::OPC_LOAD: begin
                unique case (f3)
                    3'd0:    mn = rvid_pkg::MN_LB;
                    3'd1:    mn = rvid_pkg::MN_LH;
                    3'd2:    mn = rvid_pkg::MN_LW;
                    3'd4:    mn = rvid_pkg::MN_LBU;
                    3'd5:    mn = rvid_pkg::MN_LHU;
                    default: mn = rvid_pkg::MN_UNKNOWN;
                endcase
                if (mn != rvid_pkg::MN_UNKNOWN) begin
                    imm = imm_i;
                end
            end
            rvid_pkg::OPC_STORE: begin
                unique case (f3)
                    3'd0:    mn = rvid_pkg::MN_SB;
                    3'd1:    mn = rvid_pkg::MN_SH;
                    3'd2:    mn = rvid_pkg::MN_SW;
                    default: mn = rvid_pkg::MN_UNKNOWN;
                endcase
                if (mn != rvid_pkg::MN_UNKNOWN) begin
                    imm = imm_s;
                end
            end
            rvid_pkg::OPC_IMM: begin
                unique case (f3)
                    3'd0: begin
                        mn  = rvid_pkg::MN_ADDI;
                        imm = imm_i;
                    end
                    3'd1: begin
                        mn  = rvid_pkg::MN_SLLI;
                        imm = shamt;
                    end
                    3'd2: begin
                        mn  = rvid_pkg::MN_SLTI;
                        imm = imm_i;
                    end
                    3'd3: begin
                        mn  = rvid_pkg::MN_SLTIU;
                        imm = imm_i;
                    end
                    3'd4: begin
                        mn  = rvid_pkg::MN_XORI;
                        imm = imm_i;
                    end
                    3'd5: begin
                        if (f7 == rvid_pkg::F7_BASE) begin
                            mn  = rvid_pkg::MN_SRLI;
                            imm = shamt;
                        end else if (f7 == rvid_pkg::F7_ALT) begin
                            mn  = rvid_pkg::MN_SRAI;
                            imm = shamt;
                        end
                    end
                    3'd6: begin
                        mn  = rvid_pkg::MN_ORI;
                        imm = imm_i;
                    end
                    default: begin
                        mn  = rvid_pkg::MN_ANDI;
                        imm = imm_i;
                    end
                endcase
            end
            rvid_pkg::OPC_REG: begin
                unique case (f3)
                    3'd0: begin
                        if (f7 == rvid_pkg::F7_BASE) begin
                            mn = rvid_pkg::MN_ADD;
                        end else if (f7 == rvid_pkg::F7_ALT) begin
                            mn = rvid_pkg::MN_SUB;
                        end
                    end
                    3'd1: mn = rvid_pkg::MN_SLL;
                    3'd2: mn = rvid_pkg::MN_SLT;
                    3'd3: mn = rvid_pkg::MN_SLTU;
                    3'd4: mn = rvid_pkg::MN_XOR;
                    3'd5: begin
                        if (f7 == rvid_pkg::F7_BASE) begin
                            mn = rvid_pkg::MN_SRL;
                        end else if (f7 == rvid_pkg::F7_ALT) begin
                            mn = rvid_pkg::MN_SRA;
                        end
                    end
                    3'd6:    mn = rvid_pkg::MN_OR;
                    default: mn = rvid_pkg::MN_AND;
                endcase
            end
            rvid_pkg::OPC_FENCE: begin
                if (f3 == 3'd0) begin
                    mn   = rvid_pkg::MN_FENCE;
                    pred = instr_word[27:24];
                    succ = instr_word[23:20];
                end else if (f3 == 3'd1) begin
                    mn = rvid_pkg::MN_FENCE_I;
                end
            end
            rvid_pkg::OPC_SYSTEM: begin
                unique case (f3)
                    3'd0: begin
                        if (f12 == rvid_pkg::F12_ECALL) begin
                            mn = rvid_pkg::MN_ECALL;
                        end else if (f12 == rvid_pkg::F12_EBREAK) begin
                            mn = rvid_pkg::MN_EBREAK;
                        end
                    end
                    3'd1:    mn = rvid_pkg::MN_CSRRW;
                    3'd2:    mn = rvid_pkg::MN_CSRRS;
                    3'd3:    mn = rvid_pkg::MN_CSRRC;
                    3'd5:    mn = rvid_pkg::MN_CSRRWI;
                    3'd6:    mn = rvid_pkg::MN_CSRRSI;
                    3'd7:    mn = rvid_pkg::MN_CSRRCI;
                    default: mn = rvid_pkg::MN_UNKNOWN;
                endcase
                if (f3 != 3'd0 && mn != rvid_pkg::MN_UNKNOWN) begin
                    csr = f12;
                end
            end
            default: begin
                mn = rvid_pkg::MN_UNKNOWN;
            end
        endcase
    end

    assign dec.mnemonic       = mn;
    assign dec.dest_reg       = instr_word[11:7];
    assign dec.src1_reg       = instr_word[19:15];
    assign dec.src2_reg       = instr_word[24:20];
    assign dec.immediate      = imm;
    assign dec.csr_number     = csr;
    assign dec.fence_pred     = pred;
    assign dec.fence_succ     = succ;
    assign dec.target_address = tgt;

endmodule
`default_nettype wire

// File: hdl/rv32i_instruction_decoder.sv
// Top level: registered RV32I instruction decoder with stream input and output.
// Path: input beat to result beat through the input register, then the result register.
// Throughput: one instruction per cycle unless stalled; one decode pass between the registers.
// Ready toward the source follows the result stage, so a stalled result still lets one beat in.
// Reset: synchronous active-low aresetn empties both stages; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module rv32i_instruction_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // instr_word[31:0], instr_address[63:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata    // mnemonic[5:0], dest_reg[10:6], src1_reg[15:11],
                                        // src2_reg[20:16], immediate[41:21],
                                        // csr_number[53:42], fence_pred[57:54],
                                        // fence_succ[61:58], target_address[93:62], zero
);

    logic           in_valid_reg;
    logic           in_valid_next;
    logic [31:0]    in_word_reg;
    logic [31:0]    in_addr_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    rvid_pkg::dec_t out_data_reg;
    rvid_pkg::dec_t dec;
    logic           out_load;
    logic           in_load;

    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = in_valid_reg;
        end
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_word_reg <= s_tdata[31:0];
            in_addr_reg <= s_tdata[63:32];
        end
        if (out_load && in_valid_reg) begin
            out_data_reg <= dec;
        end
    end

    rvid_decode u_decode (
        .instr_word    (in_word_reg),
        .instr_address (in_addr_reg),
        .dec           (dec)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_data_reg.target_address,
                       out_data_reg.fence_succ,
                       out_data_reg.fence_pred,
                       out_data_reg.csr_number,
                       out_data_reg.immediate,
                       out_data_reg.src2_reg,
                       out_data_reg.src1_reg,
                       out_data_reg.dest_reg,
                       out_data_reg.mnemonic};

`ifndef SYNTHESIS
    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_full_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while both stages full and stalled");

    a_unknown_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_data_reg.mnemonic == rvid_pkg::MN_UNKNOWN) |->
        (out_data_reg.immediate == '0 && out_data_reg.target_address == '0 &&
         out_data_reg.csr_number == '0))
        else $error("unknown instruction carries decoded fields");

    a_target_only_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_data_reg.target_address != '0) |->
        (out_data_reg.mnemonic == rvid_pkg::MN_JAL ||
         (out_data_reg.mnemonic >= rvid_pkg::MN_BEQ &&
          out_data_reg.mnemonic <= rvid_pkg::MN_BGEU)))
        else $error("target address on a non-flow instruction");
`endif

endmodule
`default_nettype wire

// File: tb/tb_rv32i_instruction_decoder.sv
// Self-checking stream testbench for the RV32I instruction decoder.
`timescale 1ns / 1ps

// funct3 of each mnemonic, indexed by mnemonic code
localparam logic [2:0] FUNCT3_OF [48] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd0, 3'd1, 3'd4, 3'd5, 3'd6, 3'd7,
    3'd0, 3'd1, 3'd2, 3'd4, 3'd5,
    3'd0, 3'd1, 3'd2,
    3'd0, 3'd2, 3'd3, 3'd4, 3'd6, 3'd7, 3'd1, 3'd5, 3'd5,
    3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd5, 3'd6, 3'd7,
    3'd0, 3'd1,
    3'd0, 3'd0,
    3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd7
};

typedef struct {
    logic [31:0]     word;
    logic [31:0]     addr;
    rvid_pkg::dec_t  rec;
} decode_expect_t;

class decode_scoreboard;
    decode_expect_t pending_decodes[$];
    int             errors;
    int             n_decoded;
    int             n_unknown;
    bit [47:0]      mnemonics_seen;

    function automatic logic [5:0] match_funct3(logic [2:0] f3, logic [5:0] lo,
                                                logic [5:0] hi);
        logic [5:0] found;
        found = rvid_pkg::MN_UNKNOWN;
        for (int m = int'(lo); m <= int'(hi); m++) begin
            if (FUNCT3_OF[m] == f3) found = m[5:0];
        end
        return found;
    endfunction

    function automatic rvid_pkg::dec_t decode_rv32i(logic [31:0] w, logic [31:0] pc);
        rvid_pkg::dec_t r;
        logic [6:0]     opc;
        logic [2:0]     f3;
        logic [6:0]     f7;
        logic [11:0]    f12;
        logic [20:0]    imm_u, imm_i, imm_s, imm_b, imm_j, shamt;
        opc   = w[6:0];
        f3    = w[14:12];
        f7    = w[31:25];
        f12   = w[31:20];
        imm_u = {w[31], w[31:12]};
        imm_i = {{9{w[31]}}, w[31:20]};
        imm_s = {{9{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_j = {w[31], w[19:12], w[20], w[30:21], 1'b0};
        shamt = {16'd0, w[24:20]};
        r          = '0;
        r.dest_reg = w[11:7];
        r.src1_reg = w[19:15];
        r.src2_reg = w[24:20];
        case (opc)
            rvid_pkg::OPC_LUI: begin
                r.mnemonic  = rvid_pkg::MN_LUI;
                r.immediate = imm_u;
            end
            rvid_pkg::OPC_AUIPC: begin
                r.mnemonic  = rvid_pkg::MN_AUIPC;
                r.immediate = imm_u;
            end
            rvid_pkg::OPC_JAL: begin
                r.mnemonic       = rvid_pkg::MN_JAL;
                r.immediate      = imm_j;
                r.target_address = pc + {{11{imm_j[20]}}, imm_j};
            end
            rvid_pkg::OPC_JALR: begin
                r.mnemonic  = rvid_pkg::MN_JALR;
                r.immediate = imm_i;
            end
            rvid_pkg::OPC_BRANCH: begin
                r.mnemonic = match_funct3(f3, rvid_pkg::MN_BEQ, rvid_pkg::MN_BGEU);
                if (r.mnemonic != rvid_pkg::MN_UNKNOWN) begin
                    r.immediate      = imm_b;
                    r.target_address = pc + {{11{imm_b[20]}}, imm_b};
                end
            end
            rvid_pkg::OPC_LOAD: begin
                r.mnemonic = match_funct3(f3, rvid_pkg::MN_LB, rvid_pkg::MN_LHU);
                if (r.mnemonic != rvid_pkg::MN_UNKNOWN) r.immediate = imm_i;
            end
            rvid_pkg::OPC_STORE: begin
                r.mnemonic = match_funct3(f3, rvid_pkg::MN_SB, rvid_pkg::MN_SW);
                if (r.mnemonic != rvid_pkg::MN_UNKNOWN) r.immediate = imm_s;
            end
            rvid_pkg::OPC_IMM: begin
                if (f3 == FUNCT3_OF[rvid_pkg::MN_SRLI]) begin
                    if (f7 == rvid_pkg::F7_BASE) r.mnemonic = rvid_pkg::MN_SRLI;
                    else if (f7 == rvid_pkg::F7_ALT) r.mnemonic = rvid_pkg::MN_SRAI;
                    if (r.mnemonic != rvid_pkg::MN_UNKNOWN) r.immediate = shamt;
                end else begin
                    r.mnemonic  = match_funct3(f3, rvid_pkg::MN_ADDI, rvid_pkg::MN_SLLI);
                    r.immediate = (r.mnemonic == rvid_pkg::MN_SLLI) ? shamt : imm_i;
                end
            end
            rvid_pkg::OPC_REG: begin
                if (f3 == FUNCT3_OF[rvid_pkg::MN_ADD]) begin
                    if (f7 == rvid_pkg::F7_BASE) r.mnemonic = rvid_pkg::MN_ADD;
                    else if (f7 == rvid_pkg::F7_ALT) r.mnemonic = rvid_pkg::MN_SUB;
                end else if (f3 == FUNCT3_OF[rvid_pkg::MN_SRL]) begin
                    if (f7 == rvid_pkg::F7_BASE) r.mnemonic = rvid_pkg::MN_SRL;
                    else if (f7 == rvid_pkg::F7_ALT) r.mnemonic = rvid_pkg::MN_SRA;
                end else begin
                    r.mnemonic = match_funct3(f3, rvid_pkg::MN_SLL, rvid_pkg::MN_AND);
                end
            end
            rvid_pkg::OPC_FENCE: begin
                r.mnemonic = match_funct3(f3, rvid_pkg::MN_FENCE, rvid_pkg::MN_FENCE_I);
                if (r.mnemonic == rvid_pkg::MN_FENCE) begin
                    r.fence_pred = w[27:24];
                    r.fence_succ = w[23:20];
                end
            end
            rvid_pkg::OPC_SYSTEM: begin
                if (f3 == FUNCT3_OF[rvid_pkg::MN_ECALL]) begin
                    if (f12 == rvid_pkg::F12_ECALL) r.mnemonic = rvid_pkg::MN_ECALL;
                    else if (f12 == rvid_pkg::F12_EBREAK) r.mnemonic = rvid_pkg::MN_EBREAK;
                end else begin
                    r.mnemonic = match_funct3(f3, rvid_pkg::MN_CSRRW, rvid_pkg::MN_CSRRCI);
                    if (r.mnemonic != rvid_pkg::MN_UNKNOWN) r.csr_number = f12;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function void note_instr(logic [31:0] word, logic [31:0] addr);
        decode_expect_t e;
        e.word = word;
        e.addr = addr;
        e.rec  = decode_rv32i(word, addr);
        pending_decodes.push_back(e);
    endfunction

    function int pending();
        return pending_decodes.size();
    endfunction

    function void compare_field(string field, decode_expect_t e, logic [31:0] want,
                                logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: word %08h addr %08h: %s expected %0h, actual %0h",
                     $time, e.word, e.addr, field, want, got);
        end
    endfunction

    function void check_result(logic [95:0] beat);
        decode_expect_t e;
        rvid_pkg::dec_t got;
        if (pending_decodes.size() == 0) begin
            errors++;
            $display("%0t: result beat %024h with no instruction pending: expected none, "
                     , $time, beat, "actual one");
            return;
        end
        e   = pending_decodes.pop_front();
        got = rvid_pkg::dec_t'(beat[93:0]);
        n_decoded++;
        if (e.rec.mnemonic == rvid_pkg::MN_UNKNOWN) n_unknown++;
        else mnemonics_seen[e.rec.mnemonic] = 1'b1;
        compare_field("mnemonic", e, 32'(e.rec.mnemonic), 32'(got.mnemonic));
        compare_field("dest_reg", e, 32'(e.rec.dest_reg), 32'(got.dest_reg));
        compare_field("src1_reg", e, 32'(e.rec.src1_reg), 32'(got.src1_reg));
        compare_field("src2_reg", e, 32'(e.rec.src2_reg), 32'(got.src2_reg));
        compare_field("immediate", e, 32'(e.rec.immediate), 32'(got.immediate));
        compare_field("csr_number", e, 32'(e.rec.csr_number), 32'(got.csr_number));
        compare_field("fence_pred", e, 32'(e.rec.fence_pred), 32'(got.fence_pred));
        compare_field("fence_succ", e, 32'(e.rec.fence_succ), 32'(got.fence_succ));
        compare_field("target_address", e, e.rec.target_address, got.target_address);
        compare_field("padding", e, 32'd0, 32'(beat[95:94]));
    endfunction
endclass

module tb_rv32i_instruction_decoder;

    localparam int N_RANDOM       = 1250;
    localparam int WATCHDOG_LIMIT = 500;

    localparam logic [2:0] F3_NONE_BRANCH = 3'b010;
    localparam logic [2:0] F3_NONE_LOAD   = 3'b011;
    localparam logic [2:0] F3_NONE_STORE  = 3'b111;
    localparam logic [2:0] F3_NONE_FENCE  = 3'b110;
    localparam logic [2:0] F3_NONE_SYSTEM = 3'b100;

    localparam logic [6:0] KNOWN_OPCODES [11] = '{
        rvid_pkg::OPC_LUI, rvid_pkg::OPC_AUIPC, rvid_pkg::OPC_JAL, rvid_pkg::OPC_JALR,
        rvid_pkg::OPC_BRANCH, rvid_pkg::OPC_LOAD, rvid_pkg::OPC_STORE, rvid_pkg::OPC_IMM,
        rvid_pkg::OPC_REG, rvid_pkg::OPC_FENCE, rvid_pkg::OPC_SYSTEM
    };

    typedef enum logic [1:0] {READY_ALWAYS, READY_RANDOM, READY_BURSTY} ready_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;

    int          idle_cycles = 0;
    ready_mode_t ready_mode  = READY_ALWAYS;
    int          phase_left  = 0;
    int          stall_left  = 0;

    decode_scoreboard sb = new();

    rv32i_instruction_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_instr(s_tdata[31:0], s_tdata[63:32]);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    always @(posedge aclk) begin
        if (phase_left == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(READY_BURSTY, READY_ALWAYS));
            phase_left <= $urandom_range(400, 50);
        end else begin
            phase_left <= phase_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_RANDOM: m_tready <= ($urandom_range(3, 0) != 0);
            default: begin
                if (stall_left != 0) begin
                    stall_left <= stall_left - 1;
                    m_tready   <= 1'b0;
                end else if ($urandom_range(7, 0) == 0) begin
                    stall_left <= $urandom_range(12, 1);
                    m_tready   <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    function automatic logic [31:0] encode_mnemonic(logic [5:0] mn, logic [31:0] fill);
        logic [31:0] w;
        w = fill;
        if (mn >= rvid_pkg::MN_BEQ) w[14:12] = FUNCT3_OF[mn];
        if (mn == rvid_pkg::MN_LUI) w[6:0] = rvid_pkg::OPC_LUI;
        else if (mn == rvid_pkg::MN_AUIPC) w[6:0] = rvid_pkg::OPC_AUIPC;
        else if (mn == rvid_pkg::MN_JAL) w[6:0] = rvid_pkg::OPC_JAL;
        else if (mn == rvid_pkg::MN_JALR) w[6:0] = rvid_pkg::OPC_JALR;
        else if (mn <= rvid_pkg::MN_BGEU) w[6:0] = rvid_pkg::OPC_BRANCH;
        else if (mn <= rvid_pkg::MN_LHU) w[6:0] = rvid_pkg::OPC_LOAD;
        else if (mn <= rvid_pkg::MN_SW) w[6:0] = rvid_pkg::OPC_STORE;
        else if (mn <= rvid_pkg::MN_SRAI) w[6:0] = rvid_pkg::OPC_IMM;
        else if (mn <= rvid_pkg::MN_AND) w[6:0] = rvid_pkg::OPC_REG;
        else if (mn <= rvid_pkg::MN_FENCE_I) w[6:0] = rvid_pkg::OPC_FENCE;
        else w[6:0] = rvid_pkg::OPC_SYSTEM;
        case (mn)
            rvid_pkg::MN_SRLI, rvid_pkg::MN_ADD, rvid_pkg::MN_SRL:
                w[31:25] = rvid_pkg::F7_BASE;
            rvid_pkg::MN_SRAI, rvid_pkg::MN_SUB, rvid_pkg::MN_SRA:
                w[31:25] = rvid_pkg::F7_ALT;
            rvid_pkg::MN_ECALL:  w[31:20] = rvid_pkg::F12_ECALL;
            rvid_pkg::MN_EBREAK: w[31:20] = rvid_pkg::F12_EBREAK;
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] with_opcode_funct3(logic [6:0] opc, logic [2:0] f3);
        logic [31:0] w;
        w        = $urandom;
        w[6:0]   = opc;
        w[14:12] = f3;
        return w;
    endfunction

    function automatic logic [31:0] random_instr();
        int          sel;
        logic [31:0] w;
        sel = $urandom_range(99, 0);
        w   = $urandom;
        if (sel < 70) begin
            w = encode_mnemonic(6'($urandom_range(rvid_pkg::MN_CSRRCI, rvid_pkg::MN_LUI)), w);
        end else if (sel < 88) begin
            w[6:0] = KNOWN_OPCODES[$urandom_range(10, 0)];
        end
        return w;
    endfunction

    function automatic logic [31:0] random_addr();
        int sel;
        sel = $urandom_range(15, 0);
        if (sel == 0) return 32'h0000_0000;
        if (sel == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic send_instr(input logic [31:0] word, input logic [31:0] addr);
        s_tdata  <= {addr, word};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        int n_sent;
        int burst;
        int gap;
        bit paused;
        n_sent = 0;
        paused = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_instr(32'h0000_0000, 32'h0000_0000);
        send_instr(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int m = int'(rvid_pkg::MN_LUI); m <= int'(rvid_pkg::MN_CSRRCI); m++) begin
            send_instr(encode_mnemonic(m[5:0], $urandom), $urandom);
        end
        send_instr(encode_mnemonic(rvid_pkg::MN_LUI, 32'h8000_0000), 32'h0000_0000);
        send_instr(encode_mnemonic(rvid_pkg::MN_AUIPC, 32'h7FFF_FFFF), 32'hFFFF_FFFF);
        send_instr(encode_mnemonic(rvid_pkg::MN_JAL, 32'h8000_0000), 32'h0000_0000);
        send_instr(encode_mnemonic(rvid_pkg::MN_JAL, 32'h7FFF_F000), 32'hFFFF_FFFF);
        send_instr(encode_mnemonic(rvid_pkg::MN_BEQ, 32'h8000_0000), 32'h0000_0004);
        send_instr(encode_mnemonic(rvid_pkg::MN_BGEU, 32'h7E00_0F80), 32'hFFFF_FFF0);
        send_instr(encode_mnemonic(rvid_pkg::MN_ADDI, 32'h8000_0000), 32'h0000_0000);
        send_instr(encode_mnemonic(rvid_pkg::MN_ANDI, 32'h7FFF_FFFF), 32'hFFFF_FFFF);
        send_instr(encode_mnemonic(rvid_pkg::MN_SW, 32'hFE00_0F80), $urandom);
        send_instr(encode_mnemonic(rvid_pkg::MN_SB, 32'h8000_0000), $urandom);
        send_instr(encode_mnemonic(rvid_pkg::MN_SRAI, 32'hFFFF_FFFF), $urandom);
        send_instr(encode_mnemonic(rvid_pkg::MN_SLLI, 32'hFFFF_FFFF), $urandom);
        send_instr(encode_mnemonic(rvid_pkg::MN_XOR, 32'hFFFF_FFFF), $urandom);
        send_instr(encode_mnemonic(rvid_pkg::MN_SRLI, $urandom) | 32'h0200_0000, $urandom);
        send_instr(encode_mnemonic(rvid_pkg::MN_ADD, $urandom) | 32'h0200_0000, $urandom);
        send_instr(encode_mnemonic(rvid_pkg::MN_SRA, $urandom) ^ 32'h8000_0000, $urandom);
        send_instr(encode_mnemonic(rvid_pkg::MN_ECALL, $urandom) | 32'h0020_0000, $urandom);
        send_instr(encode_mnemonic(rvid_pkg::MN_EBREAK, 32'hFFFF_FFFF), $urandom);
        send_instr(encode_mnemonic(rvid_pkg::MN_FENCE, 32'hFFFF_FFFF), $urandom);
        send_instr(with_opcode_funct3(rvid_pkg::OPC_BRANCH, F3_NONE_BRANCH), $urandom);
        send_instr(with_opcode_funct3(rvid_pkg::OPC_LOAD, F3_NONE_LOAD), $urandom);
        send_instr(with_opcode_funct3(rvid_pkg::OPC_STORE, F3_NONE_STORE), $urandom);
        send_instr(with_opcode_funct3(rvid_pkg::OPC_FENCE, F3_NONE_FENCE), $urandom);
        send_instr(with_opcode_funct3(rvid_pkg::OPC_SYSTEM, F3_NONE_SYSTEM), $urandom);
        drain_results();

        while (n_sent < N_RANDOM) begin
            burst = ($urandom_range(9, 0) == 0) ? 200 : $urandom_range(40, 1);
            for (int b = 0; b < burst && n_sent < N_RANDOM; b++) begin
                send_instr(random_instr(), random_addr());
                n_sent++;
            end
            if (!paused && n_sent >= N_RANDOM / 2) begin
                drain_results();
                paused = 1'b1;
            end else begin
                gap = $urandom_range(6, 0);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        $display("Checked %0d decoded beats, %0d of them unknown words.",
                 sb.n_decoded, sb.n_unknown);
        $display("Saw %0d of 47 mnemonics; %0d field mismatches.",
                 $countones(sb.mnemonics_seen[47:1]), sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/rvid_pkg.sv
hdl/rvid_decode.sv
hdl/rv32i_instruction_decoder.sv
tb/tb_rv32i_instruction_decoder.sv
